// File: sv/text_console_character_writer_defines.svh
// Assertion macros for the text console character writer RTL.
// Depends on nothing; included by tccw_back.sv, which carries concurrent checks.
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCCW_CHECK(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCCW_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tccw_pkg.sv
// Package for the text console character writer: widths, codes, request types.
// Used by every RTL file of the block; depends on nothing.
package tccw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;
  localparam int QUEUE_DEPTH = 2;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

  localparam logic [0:0] REG_TEXT_ATTRIBUTE = 1'b0;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
    logic [CELL_W-1:0] cell_data;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
    logic              in_range;
  } op_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_READ,
    BK_CLEAR,
    BK_COPY,
    BK_BLANK
  } back_state_t;

  function automatic logic [CELL_W-1:0] blank_cell(input logic [ATTR_W-1:0] attr);
    return {attr, CH_SPACE};
  endfunction

endpackage

// File: sv/tccw_ifs.sv
// Valid/ready channel interfaces for requests and results.
// Depends on tccw_pkg for the payload types.
interface tccw_in_if;
  logic               valid;
  logic               ready;
  tccw_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tccw_out_if;
  logic                valid;
  logic                ready;
  tccw_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: sv/text_console_character_writer.sv
// Put, newline, backspace and unused commands pass the queue and result register; a read also
// passes the memory read register, a clear sweeps every cell, a scroll copies rows up and
// blanks the last row. One simple request per cycle while the result register is free; a read,
// clear or scroll holds the queue, a sweep stalls input. Reset: synchronous; the screen memory
// is then swept once, with in_ch.ready low while configuration writes are still taken.
// Top level: APB attribute register, front decoder, request queue and back end. Uses tccw_pkg.
module text_console_character_writer #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  input  logic                        clk,
  input  logic                        rst,
  tccw_in_if.sink                     in_ch,
  tccw_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tccw_pkg::APB_AW-1:0] paddr,
  input  logic [tccw_pkg::APB_DW-1:0] pwdata,
  output logic [tccw_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import tccw_pkg::*;

  logic [ATTR_W-1:0] text_attribute;
  logic              reg_sel;
  logic              init_busy;
  logic              q_full;
  logic              q_valid;
  logic              push;
  logic              pop;
  op_t               push_op;
  op_t               q_op;

  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_AW-1:2] == REG_TEXT_ATTRIBUTE;
  assign prdata  = reg_sel ? APB_DW'(text_attribute) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      text_attribute <= pwdata[ATTR_W-1:0];
    end
  end

  tccw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_ch     (in_ch),
    .init_busy (init_busy),
    .q_full    (q_full),
    .push      (push),
    .op        (push_op)
  );

  tccw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .q_valid (q_valid),
    .q_full  (q_full),
    .q_op    (q_op)
  );

  tccw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .pop       (pop),
    .attr      (text_attribute),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

endmodule

// File: sv/tccw_front.sv
// Front end: accepts requests and decodes them into screen operations.
// Depends on tccw_pkg and the tccw_in_if interface.
module tccw_front #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  tccw_in_if.sink        in_ch,
  input  logic           init_busy,
  input  logic           q_full,
  output logic           push,
  output tccw_pkg::op_t  op
);
  import tccw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  assign in_ch.ready = !init_busy && !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    op.char_code  = in_ch.payload.char_code;
    op.cell_index = in_ch.payload.cell_index;
    op.in_range   = 32'(in_ch.payload.cell_index) < 32'(CELLS);
    case (in_ch.payload.command)
      CMD_PUT: begin
        if (in_ch.payload.char_code == CH_NEWLINE) begin
          op.kind = OP_NEWLINE;
        end else if (in_ch.payload.char_code == CH_BACKSPACE) begin
          op.kind = OP_BACKSPACE;
        end else begin
          op.kind = OP_PUT;
        end
      end
      CMD_CLEAR: op.kind = OP_CLEAR;
      CMD_READ:  op.kind = OP_READ;
      default:   op.kind = OP_NOP;
    endcase
  end

endmodule

// File: sv/tccw_fifo.sv
// Short queue of decoded operations between the front and back ends.
// Depends on tccw_pkg for the operation type.
module tccw_fifo #(
  parameter int DEPTH = tccw_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tccw_pkg::op_t push_op,
  input  logic          pop,
  output logic          q_valid,
  output logic          q_full,
  output tccw_pkg::op_t q_op
);
  import tccw_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  op_t           entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign q_valid = count != '0;
  assign q_full  = count == NW'(DEPTH);
  assign q_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/tccw_back.sv
// Back end: cursor, screen memory, clear and scroll sweeps, result register.
// Depends on tccw_pkg, tccw_out_if and the assertion macro header.
`include "text_console_character_writer_defines.svh"

module tccw_back #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  tccw_pkg::op_t                 q_op,
  output logic                          pop,
  input  logic [tccw_pkg::ATTR_W-1:0]   attr,
  output logic                          init_busy,
  tccw_out_if.source                    out_ch
);
  import tccw_pkg::*;

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int AW        = $clog2(CELLS);
  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

  logic [CELL_W-1:0] screen [CELLS];
  logic [CELL_W-1:0] rd_data;
  logic              we;
  logic              re;
  logic [AW-1:0]     wa;
  logic [AW-1:0]     ra;
  logic [CELL_W-1:0] wd;

  back_state_t   state, state_next;
  logic [AW-1:0] cnt, cnt_next;
  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic [AW-1:0] caddr, caddr_next;
  logic          cp_pend, cp_pend_next;
  logic [AW-1:0] cp_addr, cp_addr_next;
  logic          rd_ok, rd_ok_next;
  logic          res_valid;
  out_item_t     res, res_new;
  logic          load;
  logic          res_scrolled;
  logic [CELL_W-1:0] res_data;
  logic          out_free;

  assign out_free       = !res_valid || out_ch.ready;
  assign init_busy      = state == BK_INIT;
  assign out_ch.valid   = res_valid;
  assign out_ch.payload = res;

  always_ff @(posedge clk) begin
    if (we) begin
      screen[wa] <= wd;
    end
    if (re) begin
      rd_data <= screen[ra];
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    col_next     = col;
    row_next     = row;
    caddr_next   = caddr;
    cp_pend_next = 1'b0;
    cp_addr_next = cp_addr;
    rd_ok_next   = rd_ok;
    pop          = 1'b0;
    we           = 1'b0;
    re           = 1'b0;
    wa           = caddr;
    ra           = cnt;
    wd           = blank_cell(attr);
    load         = 1'b0;
    res_scrolled = 1'b0;
    res_data     = '0;
    case (state)
      BK_INIT: begin
        we = 1'b1;
        wa = cnt;
        wd = blank_cell(ATTR_RESET);
        if (cnt == AW'(CELLS - 1)) begin
          state_next = BK_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      BK_IDLE: begin
        if (q_valid && out_free) begin
          pop = 1'b1;
          case (q_op.kind)
            OP_PUT: begin
              we = 1'b1;
              wd = {attr, q_op.char_code};
              if (col == CW'(COLUMNS - 1)) begin
                col_next = '0;
                if (row == RW'(ROWS - 1)) begin
                  caddr_next = AW'(LAST_BASE);
                  cnt_next   = '0;
                  state_next = BK_COPY;
                end else begin
                  row_next   = row + 1'b1;
                  caddr_next = caddr + 1'b1;
                  load       = 1'b1;
                end
              end else begin
                col_next   = col + 1'b1;
                caddr_next = caddr + 1'b1;
                load       = 1'b1;
              end
            end
            OP_NEWLINE: begin
              col_next = '0;
              if (row == RW'(ROWS - 1)) begin
                caddr_next = AW'(LAST_BASE);
                cnt_next   = '0;
                state_next = BK_COPY;
              end else begin
                row_next   = row + 1'b1;
                caddr_next = caddr - AW'(col) + AW'(COLUMNS);
                load       = 1'b1;
              end
            end
            OP_BACKSPACE: begin
              if (col != '0) begin
                we         = 1'b1;
                wa         = caddr - 1'b1;
                col_next   = col - 1'b1;
                caddr_next = caddr - 1'b1;
              end
              load = 1'b1;
            end
            OP_CLEAR: begin
              col_next   = '0;
              row_next   = '0;
              caddr_next = '0;
              cnt_next   = '0;
              state_next = BK_CLEAR;
            end
            OP_READ: begin
              re         = 1'b1;
              ra         = AW'(q_op.cell_index);
              rd_ok_next = q_op.in_range;
              state_next = BK_READ;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        if (out_free) begin
          load       = 1'b1;
          res_data   = rd_ok ? rd_data : '0;
          state_next = BK_IDLE;
        end
      end
      BK_CLEAR: begin
        we = 1'b1;
        wa = cnt;
        if (cnt == AW'(CELLS - 1)) begin
          if (out_free) begin
            load       = 1'b1;
            cnt_next   = '0;
            state_next = BK_IDLE;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      BK_COPY: begin
        if (cp_pend) begin
          we = 1'b1;
          wa = cp_addr;
          wd = rd_data;
        end
        if (cnt == AW'(LAST_BASE)) begin
          state_next = BK_BLANK;
        end else begin
          re           = 1'b1;
          ra           = cnt + AW'(COLUMNS);
          cp_pend_next = 1'b1;
          cp_addr_next = cnt;
          cnt_next     = cnt + 1'b1;
        end
      end
      BK_BLANK: begin
        we = 1'b1;
        wa = cnt;
        if (cnt == AW'(CELLS - 1)) begin
          if (out_free) begin
            load         = 1'b1;
            res_scrolled = 1'b1;
            cnt_next     = '0;
            state_next   = BK_IDLE;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
    res_new.cursor_col = COL_W'(col_next);
    res_new.cursor_row = ROW_W'(row_next);
    res_new.scrolled   = res_scrolled;
    res_new.cell_data  = res_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_INIT;
      cnt       <= '0;
      col       <= '0;
      row       <= '0;
      caddr     <= '0;
      cp_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      col     <= col_next;
      row     <= row_next;
      caddr   <= caddr_next;
      cp_pend <= cp_pend_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_addr <= cp_addr_next;
    rd_ok   <= rd_ok_next;
    if (load) begin
      res <= res_new;
    end
  end

  `TCCW_CHECK(a_init_no_pop, clk, rst, state == BK_INIT, !pop, "Request taken during init.")
  `TCCW_CHECK(a_cursor_bounds, clk, rst, 1'b1, (32'(col) < 32'(COLUMNS)) && (32'(row) < 32'(ROWS)), "Cursor off screen.")
  `TCCW_CHECK(a_write_in_range, clk, rst, we, 32'(wa) < 32'(CELLS), "Write beyond screen.")
  `TCCW_CHECK_NEXT(a_scroll_row, clk, rst, load && res_scrolled, res_valid && (res.cursor_row == ROW_W'(ROWS - 1)), "Scroll left cursor off last row.")

endmodule

// File: bench/tb_text_console_character_writer.sv
// Self-checking testbench for the text console character writer: requests go in on a
// valid/ready channel, results are checked against a predictor of screen and cursor.
// Depends on tccw_pkg, the channel interfaces in tccw_ifs.sv and the block itself.
`timescale 1ns / 100ps

module tb_text_console_character_writer;
  import tccw_pkg::*;

  localparam int COLS = DEF_COLUMNS;
  localparam int ROWS = DEF_ROWS;
  localparam int CELLS = COLS * ROWS;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 16;
  localparam longint CYCLE_LIMIT = 6_000_000;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  tccw_in_if in_ch ();
  tccw_out_if out_ch ();

  text_console_character_writer dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  logic [CELL_W-1:0] screen_image [0:CELLS-1];
  int unsigned pred_col;
  int unsigned pred_row;
  logic [ATTR_W-1:0] attribute_now;
  out_item_t pending_results[$];

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int errors;
  longint cycle_count;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_text_console_character_writer: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic out_item_t console_step(in_item_t req);
    out_item_t res;
    logic [CELL_W-1:0] blank;
    logic scrolled_now;
    blank = {attribute_now, CH_SPACE};
    scrolled_now = 1'b0;
    res = '0;
    case (req.command)
      CMD_PUT: begin
        if (req.char_code == CH_NEWLINE) begin
          pred_col = 0;
          pred_row++;
        end else if (req.char_code == CH_BACKSPACE) begin
          if (pred_col > 0) begin
            pred_col--;
            screen_image[pred_row * COLS + pred_col] = blank;
          end
        end else begin
          screen_image[pred_row * COLS + pred_col] = {attribute_now, req.char_code};
          pred_col++;
        end
        if (pred_col >= COLS) begin
          pred_col = 0;
          pred_row++;
        end
        if (pred_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLS; i++) screen_image[i] = screen_image[i + COLS];
          for (int x = 0; x < COLS; x++) screen_image[CELLS - COLS + x] = blank;
          pred_row = ROWS - 1;
          scrolled_now = 1'b1;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_image[i] = blank;
        pred_col = 0;
        pred_row = 0;
      end
      CMD_READ: begin
        if (req.cell_index < CELLS) res.cell_data = screen_image[req.cell_index];
      end
      default: ;
    endcase
    res.cursor_col = pred_col[COL_W-1:0];
    res.cursor_row = pred_row[ROW_W-1:0];
    res.scrolled = scrolled_now;
    return res;
  endfunction

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none, got %p",
                 $time, out_ch.payload);
      end else begin
        want = pending_results.pop_front();
        report_field("cursor_col", want.cursor_col, out_ch.payload.cursor_col);
        report_field("cursor_row", want.cursor_row, out_ch.payload.cursor_row);
        report_field("scrolled", want.scrolled, out_ch.payload.scrolled);
        report_field("cell_data", want.cell_data, out_ch.payload.cell_data);
      end
    end
  end

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                              logic [IDX_W-1:0] idx);
    in_item_t req;
    req.command = cmd;
    req.char_code = ch;
    req.cell_index = idx;
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.payload = req;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(console_step(req));
  endtask

  task automatic put_char(logic [CHAR_W-1:0] ch);
    send_request(CMD_PUT, ch, IDX_W'($urandom_range(2047)));
  endtask

  task automatic read_cell(logic [IDX_W-1:0] idx);
    send_request(CMD_READ, CHAR_W'($urandom_range(255)), idx);
  endtask

  task automatic clear_screen();
    send_request(CMD_CLEAR, CHAR_W'($urandom_range(255)), IDX_W'($urandom_range(2047)));
  endtask

  function automatic logic [CHAR_W-1:0] printable_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(255));
    while (c == CH_NEWLINE || c == CH_BACKSPACE);
    return c;
  endfunction

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The attribute is only changed once every request has completed.
  task automatic set_attribute(logic [ATTR_W-1:0] attr);
    drain_results();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = APB_AW'(REG_TEXT_ATTRIBUTE * 4);
    pwdata = APB_DW'(attr);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    attribute_now = attr;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic test_extremes();
    read_cell(11'd0);
    read_cell(IDX_W'(CELLS - 1));
    read_cell(IDX_W'(CELLS));
    read_cell(11'h7FF);
    put_char(CH_BACKSPACE);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h80);
    put_char(8'h41);
    put_char(CH_BACKSPACE);
    read_cell(11'd3);
    read_cell(11'd2);
    put_char(CH_NEWLINE);
    send_request(CMD_UNUSED, 8'hFF, 11'h7FF);
    send_request(CMD_UNUSED, 8'h00, 11'h000);
    put_char(8'h7F);
    send_request(CMD_CLEAR, 8'hFF, 11'h7FF);
    read_cell(11'd0);
    read_cell(IDX_W'(COLS + 1));
  endtask

  task automatic test_wrap_and_scroll();
    clear_screen();
    repeat (COLS - 1) put_char(printable_char());
    read_cell(IDX_W'(COLS - 2));
    put_char(printable_char());
    read_cell(IDX_W'(COLS - 1));
    put_char(CH_BACKSPACE);
    repeat (ROWS - 2) put_char(CH_NEWLINE);
    repeat (COLS) put_char(printable_char());
    read_cell(IDX_W'(CELLS - 2 * COLS));
    read_cell(IDX_W'(CELLS - COLS));
    put_char(printable_char());
    put_char(CH_BACKSPACE);
    put_char(CH_NEWLINE);
    read_cell(IDX_W'(CELLS - COLS - 1));
    read_cell(IDX_W'(CELLS - 1));
  endtask

  task automatic test_random_traffic(int n);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 12);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(99);
          if (pick < 8) begin
            put_char(CH_BACKSPACE);
          end else if (pick < 18) begin
            read_cell(IDX_W'(pred_row * COLS + $urandom_range(COLS - 1)));
          end else begin
            put_char(printable_char());
          end
        end
        put_char(CH_NEWLINE);
        sent += len + 1;
      end else if (pick < 82) begin
        len = $urandom_range(1, 5);
        repeat (len) read_cell(IDX_W'($urandom_range(2047)));
        sent += len;
      end else if (pick < 85) begin
        clear_screen();
        sent++;
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) send_request(CMD_W'($urandom_range(3)), CHAR_W'($urandom_range(255)),
                                  IDX_W'($urandom_range(2047)));
        sent += len;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    errors = 0;
    cycle_count = 0;
    attribute_now = ATTR_RESET;
    pred_col = 0;
    pred_row = 0;
    for (int i = 0; i < CELLS; i++) screen_image[i] = {ATTR_RESET, CH_SPACE};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // Wait for the clearing pass after reset before sending requests.
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);

    test_extremes();
    set_attribute(8'hFF);
    test_wrap_and_scroll();

    set_attribute(8'h00);
    test_random_traffic(70);

    set_attribute(ATTR_W'($urandom_range(255)));
    src_idle_pct = 57;
    test_random_traffic(70);

    set_attribute(8'hFF);
    src_idle_pct = 0;
    sink_stall_pct = 57;
    test_random_traffic(70);

    set_attribute(ATTR_W'($urandom_range(255)));
    src_idle_pct = 8;
    sink_stall_pct = 8;
    test_random_traffic(70);

    drain_results();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_text_console_character_writer: clean");
    end else begin
      $display("tb_text_console_character_writer: errors");
    end
    $finish;
  end

endmodule
